[rtl/core/imu_ssr_pkg.sv]
// Shared types, constants and helpers for the IMU sample scale and rotate block.
package imu_ssr_pkg;

    // Fixed-point formats.
    localparam int COEF_FRAC_BITS = 16;
    localparam int OUT_FRAC_BITS  = 16;
    localparam int SENS_FRAC      = 32;
    localparam int SHIFT          = COEF_FRAC_BITS + SENS_FRAC - OUT_FRAC_BITS;

    // Datapath widths.
    localparam int COEF_W = 18;
    localparam int RAW_W  = 16;
    localparam int PROD_W = COEF_W + RAW_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int MAG_W  = PROD_W;
    localparam int HALF_W = MAG_W / 2;
    localparam int SENS_W = 25;
    localparam int PART_W = HALF_W + SENS_W;
    localparam int OUT_W  = 32;
    localparam int ROW_W  = 3 * COEF_W;
    localparam int TEMP_W = 11;

    // Queue depths.
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

    // Sample kinds.
    localparam logic [1:0] KIND_ACCEL = 2'd0;
    localparam logic [1:0] KIND_GYRO  = 2'd1;
    localparam logic [1:0] KIND_TEMP  = 2'd2;

    // Configuration register indices.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROW_W;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_RANGE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_RANGE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW2    = 3'd4;

    // Sensitivities as round(sensitivity * 2^32).
    localparam logic [SENS_W-1:0] ACC_SENS_TAB [4] = '{
        SENS_W'((64'd3  * 64'd6121 * 64'd131072 + 64'd312) / 64'd625),
        SENS_W'((64'd6  * 64'd6121 * 64'd131072 + 64'd312) / 64'd625),
        SENS_W'((64'd12 * 64'd6121 * 64'd131072 + 64'd312) / 64'd625),
        SENS_W'((64'd24 * 64'd6121 * 64'd131072 + 64'd312) / 64'd625)
    };
    localparam logic [SENS_W-1:0] GYRO_SENS_TAB [5] = '{
        SENS_W'(4575276), SENS_W'(2287638), SENS_W'(1143819),
        SENS_W'(571909), SENS_W'(285955)
    };
    localparam logic [2:0] GYRO_CODE_MAX = 3'd4;

    // Input sample and result transactions.
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic [7:0] byte4;
        logic [7:0] byte5;
    } t_sample;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [OUT_W-1:0] out_x;
        logic signed [OUT_W-1:0] out_y;
        logic signed [OUT_W-1:0] out_z;
    } t_result;

    // Classified job handed from the front part to the back part.
    typedef struct packed {
        logic [1:0]              kind;
        logic signed [RAW_W-1:0] raw_x;
        logic signed [RAW_W-1:0] raw_y;
        logic signed [RAW_W-1:0] raw_z;
        logic [SENS_W-1:0]       sens;
        logic signed [OUT_W-1:0] temp;
    } t_job;

    typedef logic [2:0][ROW_W-1:0] t_rot_rows;

    // Saturate a wide signed value to the 32-bit output range.
    function automatic logic signed [OUT_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] max_v;
        logic signed [63:0] min_v;
        max_v = 64'sd2147483647;
        min_v = -64'sd2147483648;
        if (v > max_v) begin
            return max_v[OUT_W-1:0];
        end else if (v < min_v) begin
            return min_v[OUT_W-1:0];
        end
        return v[OUT_W-1:0];
    endfunction

endpackage

[rtl/core/imu_ssr_fifo.sv]
// Small synchronous queue used between the block's parts.
module imu_ssr_fifo
    import imu_ssr_pkg::*;
#(
    parameter type t_item = logic,
    parameter int  DEPTH  = 4,
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W  = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_item            i_item,
    input  logic             i_pop,
    output t_item            o_item,
    output logic [CNT_W-1:0] o_count
);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    // Pointer advance with wrap at the last entry.
    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    // Control state: pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    // The surrounding logic must never overfill or underrun the queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> (r_count != CNT_W'(DEPTH)))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue read while empty");

endmodule

[rtl/core/imu_ssr_front.sv]
// Front part: accepts raw samples, classifies them and queues the jobs.
module imu_ssr_front
    import imu_ssr_pkg::*;
#(
    parameter int MID_DEPTH = imu_ssr_pkg::MID_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    output logic    o_full,
    input  t_sample i_sample,
    input  logic [1:0] i_accel_range,
    input  logic [2:0] i_gyro_range,
    input  logic    i_take,
    output t_job    o_job,
    output logic    o_job_valid
);

    localparam int CNT_W = $clog2(MID_DEPTH + 1);

    t_job                     job;
    logic [CNT_W-1:0]         mid_count;
    logic [2:0]               gyro_code;
    logic signed [TEMP_W-1:0] temp_code;
    logic signed [63:0]       temp_wide;
    logic                     accept;

    assign accept = i_push && !o_full;

    // Classify the sample: raw axes, sensitivity and temperature.
    always_comb begin
        gyro_code = (i_gyro_range > GYRO_CODE_MAX) ? GYRO_CODE_MAX : i_gyro_range;
        temp_code = $signed({i_sample.byte0, i_sample.byte1[7:5]});
        temp_wide = (64'(temp_code) <<< (OUT_FRAC_BITS - 3)) +
                    (64'sd23 <<< OUT_FRAC_BITS);

        job       = '0;
        job.kind  = i_sample.action;
        job.raw_x = $signed({i_sample.byte1, i_sample.byte0});
        job.raw_y = $signed({i_sample.byte3, i_sample.byte2});
        job.raw_z = $signed({i_sample.byte5, i_sample.byte4});
        job.temp  = sat32(temp_wide);
        unique case (i_sample.action)
            KIND_ACCEL: begin
                job.sens = ACC_SENS_TAB[i_accel_range];
            end
            KIND_GYRO: begin
                job.sens = GYRO_SENS_TAB[gyro_code];
            end
            default: begin
                job.sens = '0;
            end
        endcase
    end

    // Job queue between the front and back parts.
    imu_ssr_fifo #(
        .t_item (t_job),
        .DEPTH  (MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (job),
        .i_pop   (i_take),
        .o_item  (o_job),
        .o_count (mid_count)
    );

    assign o_full      = (mid_count == CNT_W'(MID_DEPTH));
    assign o_job_valid = (mid_count != '0);

endmodule

[rtl/core/imu_ssr_back.sv]
// Back part: rotation, scaling, rounding and the result queue.
module imu_ssr_back
    import imu_ssr_pkg::*;
#(
    parameter int OUT_DEPTH = imu_ssr_pkg::OUT_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_job,
    input  logic      i_job_valid,
    output logic      o_take,
    input  t_rot_rows i_rot_rows,
    output logic      o_empty,
    input  logic      i_pop,
    output t_result   o_result
);

    localparam int CNT_W = $clog2(OUT_DEPTH + 1);
    localparam int TOT_W = CNT_W + 2;

    // Stage 1: the nine coefficient products.
    logic                     r_v1;
    logic [1:0]               r_kind1;
    logic [SENS_W-1:0]        r_sens1;
    logic signed [OUT_W-1:0]  r_temp1;
    logic signed [PROD_W-1:0] r_prod1 [3][3];

    // Stage 2: row magnitudes and signs.
    logic                     r_v2;
    logic [1:0]               r_kind2;
    logic [SENS_W-1:0]        r_sens2;
    logic signed [OUT_W-1:0]  r_temp2;
    logic [MAG_W-1:0]         r_mag2 [3];
    logic [2:0]               r_neg2;

    // Stage 3: split partial products of magnitude times sensitivity.
    logic                     r_v3;
    logic [1:0]               r_kind3;
    logic signed [OUT_W-1:0]  r_temp3;
    logic [PART_W-1:0]        r_lo3 [3];
    logic [PART_W-1:0]        r_hi3 [3];
    logic [2:0]               r_neg3;

    logic signed [RAW_W-1:0]  raw [3];
    logic signed [SUM_W-1:0]  row_sum [3];
    logic signed [OUT_W-1:0]  row_out [3];
    t_result                  result;
    logic [CNT_W-1:0]         out_count;
    logic [TOT_W-1:0]         total;

    // Credit: results in flight plus results queued never exceed the queue depth.
    assign total  = TOT_W'(out_count) + TOT_W'(r_v1) + TOT_W'(r_v2) + TOT_W'(r_v3);
    assign o_take = i_job_valid && (total < TOT_W'(OUT_DEPTH));

    assign raw[0] = i_job.raw_x;
    assign raw[1] = i_job.raw_y;
    assign raw[2] = i_job.raw_z;

    // Valid chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= o_take;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage 1 payload: one multiplier per coefficient.
    always_ff @(posedge i_clk) begin
        r_kind1 <= i_job.kind;
        r_sens1 <= i_job.sens;
        r_temp1 <= i_job.temp;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                r_prod1[r][c] <= $signed(i_rot_rows[r][COEF_W*c +: COEF_W]) * raw[c];
            end
        end
    end

    // Row sums.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            row_sum[r] = SUM_W'(r_prod1[r][0]) + SUM_W'(r_prod1[r][1]) +
                         SUM_W'(r_prod1[r][2]);
        end
    end

    // Stage 2 payload: sign and magnitude of each row sum.
    always_ff @(posedge i_clk) begin
        r_kind2 <= r_kind1;
        r_sens2 <= r_sens1;
        r_temp2 <= r_temp1;
        for (int r = 0; r < 3; r++) begin
            r_neg2[r] <= row_sum[r][SUM_W-1];
            r_mag2[r] <= row_sum[r][SUM_W-1] ? MAG_W'(-row_sum[r]) : MAG_W'(row_sum[r]);
        end
    end

    // Stage 3 payload: the wide product is taken as two halves.
    always_ff @(posedge i_clk) begin
        r_kind3 <= r_kind2;
        r_temp3 <= r_temp2;
        r_neg3  <= r_neg2;
        for (int r = 0; r < 3; r++) begin
            r_lo3[r] <= PART_W'(r_mag2[r][HALF_W-1:0]) * PART_W'(r_sens2);
            r_hi3[r] <= PART_W'(r_mag2[r][MAG_W-1:HALF_W]) * PART_W'(r_sens2);
        end
    end

    // Recombine, round half away from zero, restore the sign and saturate.
    always_comb begin
        logic [63:0] prod;
        logic [63:0] quot;
        logic signed [63:0] signed_q;
        for (int r = 0; r < 3; r++) begin
            prod = (64'(r_hi3[r]) << HALF_W) + 64'(r_lo3[r]);
            quot = (prod + (64'd1 << (SHIFT - 1))) >> SHIFT;
            if (quot > 64'h8000_0000) begin
                quot = 64'h8000_0000;
            end
            signed_q   = r_neg3[r] ? -$signed(quot) : $signed(quot);
            row_out[r] = sat32(signed_q);
        end
    end

    // Result assembly by sample kind.
    always_comb begin
        result      = '0;
        result.kind = r_kind3;
        case (r_kind3) inside
            KIND_ACCEL, KIND_GYRO: begin
                result.out_x = row_out[0];
                result.out_y = row_out[1];
                result.out_z = row_out[2];
            end
            KIND_TEMP: begin
                result.out_x = r_temp3;
            end
            default: begin
                result.out_x = '0;
            end
        endcase
    end

    // Result queue towards the receiver.
    imu_ssr_fifo #(
        .t_item (t_result),
        .DEPTH  (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_v3),
        .i_item  (result),
        .i_pop   (i_pop && !o_empty),
        .o_item  (o_result),
        .o_count (out_count)
    );

    assign o_empty = (out_count == '0);

    // The credit scheme must keep every result in flight a place in the queue.
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        total <= TOT_W'(OUT_DEPTH))
        else $error("results in flight exceed result queue space");

endmodule

[rtl/core/imu_sample_scale_rotate.sv]
// Top level of the IMU sample scale and rotate block with its configuration registers.
//
// Usage: raw six-byte sensor reads enter through a queue-like port. A transaction
// is taken at a rising edge with push high and full low; i_sample carries the
// sample kind and the six bytes. Results leave through a second queue-like port:
// while empty is low the oldest result stands on o_result, and it is taken at an
// edge with pop high. Every sample gives exactly one result, in order.
// Accelerometer and gyroscope samples are rotated by the mounting matrix and
// scaled to Q16.16; temperature gives degrees Celsius in out_x.
// Path: a sample passes the job queue, three pipeline registers and the result queue.
// Throughput: one sample per cycle while results keep being popped, set by the fully
// pipelined multiply stages; the result queue must hold at least five entries for that
// rate. Configuration: the user must write registers through i_cfg_wr_en, i_cfg_index
// and i_cfg_wdata only while no transaction is in flight; the block does not enforce
// this. Indices above four are ignored. Reset clears both queues and the pipeline and
// sets the ranges to zero and the matrix to identity. When the receiver stops popping,
// the result queue fills, the pipeline stops drawing jobs, and full rises once the job
// queue is full.
module imu_sample_scale_rotate
    import imu_ssr_pkg::*;
#(
    parameter int MID_DEPTH = imu_ssr_pkg::MID_DEPTH,
    parameter int OUT_DEPTH = imu_ssr_pkg::OUT_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_sample               i_sample,
    output logic                  empty,
    input  logic                  pop,
    output t_result               o_result,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [1:0] r_accel_range;
    logic [2:0] r_gyro_range;
    t_rot_rows  r_rot_rows;
    t_job       job;
    logic       job_valid;
    logic       take;

    // Configuration registers; reset gives the identity matrix.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_range <= '0;
            r_gyro_range  <= '0;
            r_rot_rows[0] <= ROW_W'(1) << COEF_FRAC_BITS;
            r_rot_rows[1] <= ROW_W'(1) << (COEF_FRAC_BITS + COEF_W);
            r_rot_rows[2] <= ROW_W'(1) << (COEF_FRAC_BITS + 2 * COEF_W);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ACCEL_RANGE: r_accel_range <= i_cfg_wdata[1:0];
                CFG_GYRO_RANGE:  r_gyro_range  <= i_cfg_wdata[2:0];
                CFG_ROT_ROW0:    r_rot_rows[0] <= i_cfg_wdata;
                CFG_ROT_ROW1:    r_rot_rows[1] <= i_cfg_wdata;
                CFG_ROT_ROW2:    r_rot_rows[2] <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    imu_ssr_front #(
        .MID_DEPTH (MID_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_sample      (i_sample),
        .i_accel_range (r_accel_range),
        .i_gyro_range  (r_gyro_range),
        .i_take        (take),
        .o_job         (job),
        .o_job_valid   (job_valid)
    );

    imu_ssr_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_job_valid (job_valid),
        .o_take      (take),
        .i_rot_rows  (r_rot_rows),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule
